// ----- sv/upr_pkg.sv -----
// ----------------------------------------------------------------------------
// upr_pkg: ultrasonic presence ranger definitions
// Field widths, register indexes and reset values shared by the ranger RTL.
// ----------------------------------------------------------------------------
package upr_pkg;

    // tick counter width; holds timeout_ticks + 1 without wrapping
    localparam int COUNT_BITS = 17;

    localparam int TRIG_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int NEAR_W    = 16;
    localparam int RELEASE_W = 4;
    localparam int LOWCNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LOWCNT_W-1:0]   lowcnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // configuration register indexes
    localparam cfg_idx_t REG_TRIGGER = 2'd0;
    localparam cfg_idx_t REG_TIMEOUT = 2'd1;
    localparam cfg_idx_t REG_NEAR    = 2'd2;
    localparam cfg_idx_t REG_RELEASE = 2'd3;

    // reset values
    localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd50000;
    localparam logic [NEAR_W-1:0]    NEAR_RST    = 16'd583;
    localparam logic [RELEASE_W-1:0] RELEASE_RST = 4'd6;

    localparam lowcnt_t LOWCNT_MAX = '1;

endpackage

// ----- sv/ultrasonic_presence_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_presence_ranger: ultrasonic ranging with presence decision
// One request per microsecond tick; drives the trigger pulse, times the echo
// and keeps a near/far presence decision with a release hysteresis.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_valid / s_ready  | start_request, echo_level
//  m_      | out | m_valid / m_ready  | trigger_level, busy_res, done, failed,
//          |     |                    | echo_width, present, low_count
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One request per cycle sustained while m_ready is high. A request is
//  captured in the input register, is processed against the ranging state on
//  its way into the result register, and is then offered on m_.
//  The input register holds one request while a result is stalled, so
//  s_ready only drops when both registers are full and m_ready is low.
//  Reset (aresetn low, synchronous) empties both stages, returns to idle with
//  presence clear, and reloads the configuration defaults. cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module ultrasonic_presence_ranger (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_request,
    input  logic                   s_echo_level,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_trigger_level,
    output logic                   m_busy_res,
    output logic                   m_measurement_done,
    output logic                   m_reading_failed,
    output upr_pkg::count_t        m_echo_width,
    output logic                   m_present,
    output upr_pkg::lowcnt_t       m_low_count,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  upr_pkg::cfg_idx_t      cfg_index,
    input  upr_pkg::cfg_data_t     cfg_data
);
    import upr_pkg::*;

    // ranging phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // ---- configuration registers ----
    logic [TRIG_W-1:0]    trigger_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [NEAR_W-1:0]    near_reg;
    logic [RELEASE_W-1:0] release_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_reg <= TRIGGER_RST;
            timeout_reg <= TIMEOUT_RST;
            near_reg    <= NEAR_RST;
            release_reg <= RELEASE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TRIGGER: trigger_reg <= cfg_data[TRIG_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                REG_NEAR:    near_reg    <= cfg_data[NEAR_W-1:0];
                REG_RELEASE: release_reg <= cfg_data[RELEASE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    logic in_valid_reg;
    logic in_start_reg;
    logic in_echo_reg;
    logic advance;     // input register moves into the result register

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_start_reg <= s_start_request;
            in_echo_reg  <= s_echo_level;
        end
    end

    // ---- ranging state ----
    logic [1:0] phase_reg, phase_next;
    count_t     cnt_reg, cnt_next;
    logic       pres_reg, pres_next;
    lowcnt_t    far_reg, far_next;

    // per-tick results
    logic       trig_out;
    logic       done;
    logic       fail_out;
    count_t     width;

    logic [TRIG_W-1:0] trig_len;
    count_t            cnt_inc;
    logic              over_timeout;
    logic              is_near;
    lowcnt_t           far_upd;
    logic              pres_upd;

    // a zero trigger length behaves as one tick
    assign trig_len     = (trigger_reg == '0) ? TRIG_W'(1) : trigger_reg;
    assign cnt_inc      = cnt_reg + count_t'(1);
    assign over_timeout = cnt_inc > count_t'(timeout_reg);

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        trig_out   = 1'b0;
        done       = 1'b0;
        fail_out   = 1'b0;
        width      = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (in_start_reg) begin
                    trig_out = 1'b1;
                    if (trig_len == TRIG_W'(1)) begin
                        phase_next = PH_WAIT;
                        cnt_next   = '0;
                    end else begin
                        phase_next = PH_TRIG;
                        cnt_next   = count_t'(1);
                    end
                end
            end
            PH_TRIG: begin
                trig_out = 1'b1;
                if (cnt_inc >= count_t'(trig_len)) begin
                    phase_next = PH_WAIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_WAIT: begin
                if (in_echo_reg) begin
                    phase_next = PH_MEAS;
                    cnt_next   = count_t'(1);
                end else if (over_timeout) begin
                    // no echo in time: failed, width reported as zero
                    done     = 1'b1;
                    fail_out = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_MEAS: begin
                if (!in_echo_reg) begin
                    done  = 1'b1;
                    width = cnt_reg;
                end else if (over_timeout) begin
                    // echo held too long: capped at timeout + 1, or 2 for a zero timeout
                    done     = 1'b1;
                    fail_out = 1'b1;
                    width    = cnt_inc;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            default: ;
        endcase
        if (done) begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
        end
    end

    // presence decision; failed readings count as far
    assign is_near = !fail_out && (width < count_t'(near_reg));

    always_comb begin
        far_upd  = far_reg;
        pres_upd = pres_reg;
        if (is_near) begin
            pres_upd = 1'b1;
            far_upd  = '0;
        end else if (pres_reg && far_reg != LOWCNT_MAX) begin
            far_upd = far_reg + lowcnt_t'(1);
        end
        if (far_upd > lowcnt_t'(release_reg)) begin
            pres_upd = 1'b0;
        end
        far_next  = done ? far_upd : far_reg;
        pres_next = done ? pres_upd : pres_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            pres_reg  <= 1'b0;
            far_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pres_reg  <= pres_next;
            far_reg   <= far_next;
        end
    end

    // ---- result register ----
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_trigger_level    <= trig_out;
            m_busy_res         <= (phase_next != PH_IDLE);
            m_measurement_done <= done;
            m_reading_failed   <= fail_out;
            m_echo_width       <= width;
            m_present          <= pres_next;
            m_low_count        <= far_next;
        end
    end

    assign m_valid = out_valid_reg;

    // ---- checks ----
    // idle always leaves the counter cleared
    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (cnt_reg == '0))
        else $error("counter not cleared in idle");

    // a failed reading or a nonzero width only comes with completion
    a_fail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_reading_failed || m_echo_width != '0)) |-> m_measurement_done)
        else $error("result fields set without completion");

    // completion tick is never busy; trigger tick always is
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_measurement_done) |-> (!m_busy_res && !m_trigger_level))
        else $error("completion tick reported busy or triggering");

    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trigger_level) |-> m_busy_res)
        else $error("trigger driven while not busy");

    // a stalled result with a full input register blocks new requests
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && in_valid_reg) |-> !s_ready)
        else $error("request taken with both stages full");

endmodule
